// ===== src/ssr_pkg.sv =====
package ssr_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int MAX_REPLACE = 16;

  localparam int BYTE_W      = 8;
  localparam int CFG_LEN_W   = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  // bytes held by a low/high register pair
  localparam int STORE_BYTES = 2 * CFG_DATA_W / BYTE_W;

  localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
  localparam int RLEN_W = $clog2(MAX_REPLACE + 1);
  localparam int WPOS_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int RIDX_W = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_REPLACE_LENGTH = 3'd1,
    REG_PATTERN_LOW    = 3'd2,
    REG_PATTERN_HIGH   = 3'd3,
    REG_REPLACE_LOW    = 3'd4,
    REG_REPLACE_HIGH   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic insert;     // write accepted byte into window
    logic shift;      // drop oldest window byte
    logic clear_cnt;  // empty window after a match
    logic emit;       // load output register
    logic emit_repl;  // output byte from replacement, else window head
    logic emit_last;  // final result of this transaction
    logic idx_clear;
    logic idx_inc;
  } ssr_cmd_t;

  typedef struct packed {
    logic full;
    logic hit;
    logic rlen_zero;
    logic repl_final;
    logic cnt_zero;
    logic cnt_one;
    logic last;
    logic out_free;
  } ssr_status_t;

endpackage

// ===== src/ssr_in_if.sv =====
interface ssr_in_if;
  logic                     valid;
  logic                     ready;
  logic [ssr_pkg::BYTE_W-1:0] in_byte;
  logic                     in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== src/ssr_out_if.sv =====
interface ssr_out_if;
  logic                     valid;
  logic                     ready;
  logic [ssr_pkg::BYTE_W-1:0] out_byte;
  logic                     out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== src/ssr_ctrl.sv =====
module ssr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ssr_pkg::ssr_status_t status,
  output ssr_pkg::ssr_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_REPL  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.insert = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.full) begin
          if (status.hit) begin
            cmd.clear_cnt = 1'b1;
            cmd.idx_clear = 1'b1;
            // a deleted match with last leaves nothing to flush
            state_next = status.rlen_zero ? S_IDLE : S_REPL;
          end else if (status.out_free) begin
            cmd.emit      = 1'b1;
            cmd.shift     = 1'b1;
            cmd.emit_last = !status.last || status.cnt_one;
            // nothing left to flush when the window held one byte
            state_next    = (status.last && !status.cnt_one) ? S_FLUSH : S_IDLE;
          end
        end else begin
          state_next = status.last ? S_FLUSH : S_IDLE;
        end
      end
      S_REPL: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_repl = 1'b1;
          cmd.emit_last = status.repl_final;
          cmd.idx_inc   = 1'b1;
          if (status.repl_final) begin
            state_next = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (status.cnt_zero) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.shift     = 1'b1;
          cmd.emit_last = status.cnt_one;
          if (status.cnt_one) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_repl_window_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPL) |-> status.cnt_zero)
    else $error("window not empty while replacing");

  a_check_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> ($past(state) == S_CHECK || $past(in_valid && in_ready)))
    else $error("check state without an accepted byte");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("emit into a full output register");
`endif

endmodule

// ===== src/ssr_dpath.sv =====
module ssr_dpath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]         cfg_wr_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
  input  logic [ssr_pkg::BYTE_W-1:0]            in_byte,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ssr_pkg::BYTE_W-1:0]            out_byte,
  output logic                                  out_last,
  input  ssr_pkg::ssr_cmd_t                     cmd,
  output ssr_pkg::ssr_status_t                  status
);

  logic [ssr_pkg::CFG_LEN_W-1:0]  pattern_length;
  logic [ssr_pkg::CFG_LEN_W-1:0]  replace_length;
  logic [ssr_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [ssr_pkg::CFG_DATA_W-1:0] pattern_high;
  logic [ssr_pkg::CFG_DATA_W-1:0] replace_low;
  logic [ssr_pkg::CFG_DATA_W-1:0] replace_high;

  logic [ssr_pkg::PLEN_W-1:0] plen_eff;
  logic [ssr_pkg::RLEN_W-1:0] rlen_eff;

  logic [ssr_pkg::BYTE_W-1:0] win [ssr_pkg::MAX_PATTERN];
  logic [ssr_pkg::PLEN_W-1:0] cnt;
  logic [ssr_pkg::WPOS_W-1:0] ins_pos;
  logic [ssr_pkg::RIDX_W-1:0] rep_idx;
  logic                       last_q;

  logic [2*ssr_pkg::CFG_DATA_W-1:0] pat_word;
  logic [2*ssr_pkg::CFG_DATA_W-1:0] rep_word;
  logic [ssr_pkg::BYTE_W-1:0]       pbyte [ssr_pkg::MAX_PATTERN];
  logic [ssr_pkg::BYTE_W-1:0]       rbyte [ssr_pkg::MAX_REPLACE];
  logic [ssr_pkg::MAX_PATTERN-1:0]  lane_ok;
  logic [ssr_pkg::BYTE_W-1:0]       emit_byte;
  logic                             plen_wr;

  assign plen_wr = cfg_wr_en &&
                   (ssr_pkg::cfg_reg_t'(cfg_wr_index) == ssr_pkg::REG_PATTERN_LENGTH);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= ssr_pkg::CFG_LEN_W'(1);
      replace_length <= ssr_pkg::CFG_LEN_W'(1);
      pattern_low    <= '0;
      pattern_high   <= '0;
      replace_low    <= '0;
      replace_high   <= '0;
    end else if (cfg_wr_en) begin
      case (ssr_pkg::cfg_reg_t'(cfg_wr_index))
        ssr_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_wr_data[ssr_pkg::CFG_LEN_W-1:0];
        ssr_pkg::REG_REPLACE_LENGTH: replace_length <= cfg_wr_data[ssr_pkg::CFG_LEN_W-1:0];
        ssr_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_wr_data;
        ssr_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_wr_data;
        ssr_pkg::REG_REPLACE_LOW:    replace_low    <= cfg_wr_data;
        ssr_pkg::REG_REPLACE_HIGH:   replace_high   <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // zero pattern length counts as one; both lengths saturate
  always_comb begin
    if (pattern_length == '0) begin
      plen_eff = ssr_pkg::PLEN_W'(1);
    end else if (32'(pattern_length) > ssr_pkg::MAX_PATTERN) begin
      plen_eff = ssr_pkg::PLEN_W'(ssr_pkg::MAX_PATTERN);
    end else begin
      plen_eff = ssr_pkg::PLEN_W'(pattern_length);
    end
    if (32'(replace_length) > ssr_pkg::MAX_REPLACE) begin
      rlen_eff = ssr_pkg::RLEN_W'(ssr_pkg::MAX_REPLACE);
    end else begin
      rlen_eff = ssr_pkg::RLEN_W'(replace_length);
    end
  end

  assign pat_word = {pattern_high, pattern_low};
  assign rep_word = {replace_high, replace_low};

  for (genvar k = 0; k < ssr_pkg::MAX_PATTERN; k++) begin : g_pat
    if (k < ssr_pkg::STORE_BYTES) begin : g_stored
      assign pbyte[k] = pat_word[ssr_pkg::BYTE_W*k +: ssr_pkg::BYTE_W];
    end else begin : g_zero
      assign pbyte[k] = '0;
    end
    // lanes past the pattern length do not take part
    assign lane_ok[k] = (win[k] == pbyte[k]) ||
                        (32'(k) >= 32'(plen_eff));
  end

  for (genvar k = 0; k < ssr_pkg::MAX_REPLACE; k++) begin : g_rep
    if (k < ssr_pkg::STORE_BYTES) begin : g_stored
      assign rbyte[k] = rep_word[ssr_pkg::BYTE_W*k +: ssr_pkg::BYTE_W];
    end else begin : g_zero
      assign rbyte[k] = '0;
    end
  end

  assign ins_pos = (cnt >= plen_eff) ? ssr_pkg::WPOS_W'(plen_eff - 1'b1)
                                     : ssr_pkg::WPOS_W'(cnt);

  // window shift register, oldest byte at index 0
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      win[ins_pos] <= in_byte;
    end else if (cmd.shift) begin
      for (int i = 0; i < ssr_pkg::MAX_PATTERN - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (plen_wr) begin
      cnt <= '0;
    end else if (cmd.insert) begin
      cnt <= (cnt >= plen_eff) ? plen_eff : cnt + 1'b1;
    end else if (cmd.clear_cnt) begin
      cnt <= '0;
    end else if (cmd.shift) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      last_q <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clear) begin
      rep_idx <= '0;
    end else if (cmd.idx_inc) begin
      rep_idx <= rep_idx + 1'b1;
    end
  end

  // output register
  assign emit_byte = cmd.emit_repl ? rbyte[rep_idx] : win[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= emit_byte;
      out_last <= cmd.emit_last;
    end
  end

  always_comb begin
    status            = '0;
    status.full       = (cnt == plen_eff);
    status.hit        = &lane_ok;
    status.rlen_zero  = (rlen_eff == '0);
    status.repl_final = (ssr_pkg::RLEN_W'(rep_idx) == rlen_eff - 1'b1);
    status.cnt_zero   = (cnt == '0);
    status.cnt_one    = (cnt == ssr_pkg::PLEN_W'(1));
    status.last       = last_q;
    status.out_free   = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_cnt_bounded: assert property (@(posedge clk) disable iff (rst)
    cnt <= plen_eff)
    else $error("window count past pattern length");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.emit)
    else $error("output overwritten while stalled");

  a_plen_write_clears: assert property (@(posedge clk) disable iff (rst)
    plen_wr |=> cnt == '0)
    else $error("window not emptied on pattern length write");
`endif

endmodule

// ===== src/stream_search_and_replace_top.sv =====
// Stream search and replace.
// stream (sink): one text byte per transaction, in_last marks the final byte.
// result (source): rewritten bytes; out_last is set on the final byte caused
//   by one input transaction (an input may cause zero to 16 output bytes).
// Config: cfg_wr_en/cfg_wr_index/cfg_wr_data, written while the block is idle.
//   0 pattern_length, 1 replace_length, 2/3 pattern bytes low/high,
//   4/5 replacement bytes low/high. Writing pattern_length empties the window.
// Timing: a byte is accepted in the idle state and checked the next cycle;
//   the check state loads the first output byte, if any, into the output
//   register. A match goes on through the replace state, and a final byte
//   with window bytes left through the flush state, each emitting in turn.
//   The sequencer emits one byte per cycle while the output register is free.
// The output register lets the next input be accepted while a result waits.
// A stalled receiver holds the output register; a sequencer with a byte to
//   emit then waits, and stream.ready stays low until it is back in idle.
// Reset (synchronous, rst high): window emptied, lengths 1, byte regs zero.
module stream_search_and_replace_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  ssr_in_if.sink                            stream,
  ssr_out_if.source                         result
);

  ssr_pkg::ssr_cmd_t    cmd;
  ssr_pkg::ssr_status_t status;
  logic                 in_ready;

  assign stream.ready = in_ready;

  // sequencer: decides per cycle what enters the window and what leaves
  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // window, comparators, config registers and output register
  ssr_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data),
    .in_byte      (stream.in_byte),
    .in_last      (stream.in_last),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_byte     (result.out_byte),
    .out_last     (result.out_last),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
